// File: src/bmpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants for the BMP stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_PALETTE = 3'd1,
    PH_SKIP    = 3'd2,
    PH_PIXELS  = 3'd3,
    PH_PAD     = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_PIXEL      = 3'd0,
    ST_BAD_SIG    = 3'd1,
    ST_BAD_HDR    = 3'd2,
    ST_BAD_PLANES = 3'd3,
    ST_TOO_WIDE   = 3'd4
  } status_e;

  // Header byte positions that close a field
  localparam logic [5:0] POS_SIG_B     = 6'd0;
  localparam logic [5:0] POS_SIG_M     = 6'd1;
  localparam logic [5:0] POS_OFFSET    = 6'd13;
  localparam logic [5:0] POS_HDR_SIZE  = 6'd17;
  localparam logic [5:0] POS_WIDTH     = 6'd21;
  localparam logic [5:0] POS_HEIGHT    = 6'd25;
  localparam logic [5:0] POS_PLANES    = 6'd27;
  localparam logic [5:0] POS_DEPTH     = 6'd29;
  localparam logic [5:0] POS_PAL_COUNT = 6'd49;
  localparam logic [5:0] POS_HDR_LAST  = 6'd53;

  localparam logic [31:0] DATA_START = 32'd54;
  localparam logic [7:0]  SIG_B      = 8'h42;
  localparam logic [7:0]  SIG_M      = 8'h4D;
  localparam logic [31:0] INFO_SIZE  = 32'd40;
  localparam logic [15:0] PLANES_ONE = 16'd1;
  localparam logic [15:0] DEPTH_PAL  = 16'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] first_component;
    logic [7:0] second_component;
    logic [7:0] third_component;
    logic [2:0] status;
    logic       last_pixel;
  } out_beat_t;

endpackage

// File: src/bmpd_palette_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_palette_ram
// Palette store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bmpd_palette_ram #(
  parameter int Depth = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [23:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [23:0]   rd_data_o
);

  logic [23:0] mem_q [Depth];
  logic [23:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/bmp_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_decoder_core
// Byte-serial BMP parser: header checks, palette load, pixel emission.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | beat
//  --------+-----------+-------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o | data_byte, start_of_file
//  out     | source    | out_valid_o/out_stall_i | 3 components, status, last
//
// One input beat per cycle while in_stall_o is low. Each beat is parsed in the cycle it is
// taken; a result (if the beat makes one) passes through the stage-1 registers,
// which hold the registered palette read, and then through the output register.
// Reset is asynchronous and puts the parser at byte 0 of a file.
// A stall on the output backs up through the two result stages; the input is
// stalled only when both are full. Beats that make no result wait as well.
// ----------------------------------------------------------------------------
module bmp_stream_decoder_core #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bmpd_pkg::in_beat_t in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bmpd_pkg::out_beat_t out_beat_o
);

  import bmpd_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);       // width / column counter
  localparam int CW = $clog2(PALETTE_DEPTH + 1);   // palette count
  localparam int AW = $clog2(PALETTE_DEPTH);       // palette address
  localparam logic [CW-1:0] PAL_MAX = CW'(PALETTE_DEPTH);

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_ready, in_ready, accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !in_ready;
  assign accept     = in_valid_i && in_ready;

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  phase_e         phase_q, phase_d;
  logic [31:0]    pos_q, pos_d;
  logic [31:0]    field_q, field_d;
  logic [31:0]    offset_q, offset_d;
  logic [WW-1:0]  width_q, width_d;
  logic [15:0]    height_q, height_d;
  logic           depth8_q, depth8_d;
  logic [CW-1:0]  pal_cnt_q, pal_cnt_d;
  logic [CW-1:0]  pal_ld_q, pal_ld_d;
  logic [WW-1:0]  col_q, col_d;
  logic [15:0]    row_q, row_d;
  logic [1:0]     bip_q, bip_d;
  logic [1:0]     pad_q, pad_d;
  logic [15:0]    part_q, part_d;

  // result stage 1 (palette read in flight)
  logic [23:0]    s1_rgb_q, s1_rgb_d;
  logic           s1_pal_q, s1_pal_d;
  logic           s1_hit_q, s1_hit_d;
  logic [2:0]     s1_status_q, s1_status_d;
  logic           s1_last_q, s1_last_d;
  logic           res_valid;

  out_beat_t      out_beat_q;

  // palette port
  logic           pal_we, pal_re;
  logic [AW-1:0]  pal_waddr;
  logic [23:0]    pal_wdata, pal_rdata;

  // per-beat scratch
  phase_e          cur_phase;
  logic [31:0]     cur_pos, cur_field, v, mag, pos_nx;
  logic [7:0]      b;
  logic [WW:0]     col_nx;
  logic [16:0]     row_nx;
  logic [WW+1:0]   wx;
  logic [1:0]      rb2, pad_calc;
  logic [CW-1:0]   pal_ld_nx;
  logic            start_px, reached;

  always_comb begin
    b         = in_beat_i.data_byte;
    cur_phase = in_beat_i.start_of_file ? PH_HEADER : phase_q;
    cur_pos   = in_beat_i.start_of_file ? '0 : pos_q;
    cur_field = in_beat_i.start_of_file ? '0 : field_q;
    v         = {b, cur_field[31:8]};
    mag       = v[31] ? 32'(-v) : v;
    pos_nx    = cur_pos + 32'd1;
    reached   = pos_nx >= offset_q;
    col_nx    = {1'b0, col_q} + (WW+1)'(1);
    row_nx    = {1'b0, row_q} + 17'd1;
    wx        = {2'b00, width_q};
    rb2       = depth8_q ? wx[1:0] : 2'(wx[1:0] + {wx[0], 1'b0});
    pad_calc  = 2'(~rb2 + 2'd1);
    pal_ld_nx = pal_ld_q;
    start_px  = 1'b0;

    phase_d   = phase_q;
    pos_d     = pos_q;
    field_d   = field_q;
    offset_d  = offset_q;
    width_d   = width_q;
    height_d  = height_q;
    depth8_d  = depth8_q;
    pal_cnt_d = pal_cnt_q;
    pal_ld_d  = pal_ld_q;
    col_d     = col_q;
    row_d     = row_q;
    bip_d     = bip_q;
    pad_d     = pad_q;
    part_d    = part_q;

    res_valid   = 1'b0;
    s1_rgb_d    = '0;
    s1_pal_d    = 1'b0;
    s1_hit_d    = 1'b0;
    s1_status_d = ST_PIXEL;
    s1_last_d   = 1'b0;

    pal_we    = 1'b0;
    pal_waddr = pal_ld_q[AW-1:0];
    pal_wdata = {b, part_q};
    pal_re    = 1'b0;

    unique case (cur_phase)
      PH_HEADER: begin
        field_d  = v;
        pos_d    = pos_nx;
        pal_ld_d = '0;
        part_d   = '0;
        unique case (cur_pos[5:0])
          POS_SIG_B: begin
            if (b != SIG_B) res_valid = 1'b1;
            s1_status_d = ST_BAD_SIG;
          end
          POS_SIG_M: begin
            if (b != SIG_M) res_valid = 1'b1;
            s1_status_d = ST_BAD_SIG;
          end
          POS_OFFSET: offset_d = v;
          POS_HDR_SIZE: begin
            if (v != INFO_SIZE) res_valid = 1'b1;
            s1_status_d = ST_BAD_HDR;
          end
          POS_WIDTH: begin
            if (v > 32'(MAX_WIDTH)) res_valid = 1'b1;
            s1_status_d = ST_TOO_WIDE;
            width_d     = v[WW-1:0];
          end
          POS_HEIGHT: height_d = (|mag[31:16]) ? 16'hFFFF : mag[15:0];
          POS_PLANES: begin
            if (v[31:16] != PLANES_ONE) res_valid = 1'b1;
            s1_status_d = ST_BAD_PLANES;
          end
          POS_DEPTH: depth8_d = (v[31:16] == DEPTH_PAL);
          POS_PAL_COUNT: begin
            if (!depth8_q) begin
              pal_cnt_d = '0;
            end else if (v == 32'd0 || v > 32'(PALETTE_DEPTH)) begin
              pal_cnt_d = PAL_MAX;
            end else begin
              pal_cnt_d = v[CW-1:0];
            end
          end
          POS_HDR_LAST: begin
            bip_d = 2'd0;
            if (depth8_q && pal_cnt_q != '0 && DATA_START < offset_q) begin
              phase_d = PH_PALETTE;
            end else if (DATA_START < offset_q) begin
              phase_d = PH_SKIP;
            end else begin
              start_px = 1'b1;
            end
          end
          default: ;
        endcase
        if (res_valid) begin
          phase_d = PH_DONE;     // error: ignore the rest of the file
          pos_d   = cur_pos;
        end else if (cur_pos[5:0] != POS_HDR_LAST) begin
          phase_d = PH_HEADER;
        end
      end

      PH_PALETTE: begin
        if (bip_q == 2'd0) begin
          part_d = {part_q[15:8], b};
        end else if (bip_q == 2'd1) begin
          part_d = {b, part_q[7:0]};
        end else if (bip_q == 2'd2) begin
          pal_we    = 1'b1;
          pal_ld_nx = CW'(pal_ld_q + CW'(1));
          part_d    = '0;
        end
        pal_ld_d = pal_ld_nx;
        pos_d    = pos_nx;
        if (reached) begin
          start_px = 1'b1;
        end else if (bip_q == 2'd3) begin
          bip_d = 2'd0;
          if (pal_ld_nx >= pal_cnt_q) phase_d = PH_SKIP;
        end else begin
          bip_d = 2'(bip_q + 2'd1);
        end
      end

      PH_SKIP: begin
        pos_d = pos_nx;
        if (reached) start_px = 1'b1;
      end

      PH_PIXELS: begin
        if (depth8_q) begin
          res_valid = 1'b1;
          s1_pal_d  = 1'b1;
          s1_hit_d  = {{(CW+8){1'b0}}, b} < {8'd0, {CW{1'b0}}, pal_ld_q};
          pal_re    = 1'b1;
        end else if (bip_q < 2'd2) begin
          part_d = (bip_q == 2'd0) ? {part_q[15:8], b} : {b, part_q[7:0]};
          bip_d  = 2'(bip_q + 2'd1);
        end else begin
          res_valid = 1'b1;
          s1_rgb_d  = {b, part_q};
        end
        if (res_valid) begin
          bip_d  = 2'd0;
          part_d = '0;
          col_d  = col_nx[WW-1:0];
          if (col_nx >= {1'b0, width_q}) begin
            col_d = '0;
            row_d = row_nx[15:0];
            if (row_nx >= {1'b0, height_q}) begin
              s1_last_d = 1'b1;
              phase_d   = PH_DONE;
            end else if (pad_calc != 2'd0) begin
              pad_d   = pad_calc;
              phase_d = PH_PAD;
            end
          end
        end
      end

      PH_PAD: begin
        pad_d = 2'(pad_q - 2'd1);
        if (pad_q <= 2'd1) begin
          pad_d   = 2'd0;
          phase_d = PH_PIXELS;
        end
      end

      default: phase_d = PH_DONE;
    endcase

    if (start_px) begin
      col_d   = '0;
      row_d   = '0;
      bip_d   = 2'd0;
      part_d  = '0;
      pad_d   = 2'd0;
      phase_d = (width_q == '0 || height_q == '0) ? PH_DONE : PH_PIXELS;
    end
  end

  bmpd_palette_ram #(
    .Depth (PALETTE_DEPTH),
    .AW    (AW)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_en_i   (accept && pal_we),
    .wr_addr_i (pal_waddr),
    .wr_data_i (pal_wdata),
    .rd_en_i   (accept && pal_re),
    .rd_addr_i (b[AW-1:0]),
    .rd_data_o (pal_rdata)
  );

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = res_valid;
    end else if (out_ready) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_ready ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      field_q     <= '0;
      offset_q    <= '0;
      width_q     <= '0;
      height_q    <= '0;
      depth8_q    <= 1'b0;
      pal_cnt_q   <= '0;
      pal_ld_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      bip_q       <= '0;
      pad_q       <= '0;
      part_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        field_q   <= field_d;
        offset_q  <= offset_d;
        width_q   <= width_d;
        height_q  <= height_d;
        depth8_q  <= depth8_d;
        pal_cnt_q <= pal_cnt_d;
        pal_ld_q  <= pal_ld_d;
        col_q     <= col_d;
        row_q     <= row_d;
        bip_q     <= bip_d;
        pad_q     <= pad_d;
        part_q    <= part_d;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result payload registers
  // --------------------------------------------------------------------------
  logic [23:0] s1_color;

  assign s1_color = s1_pal_q ? (s1_hit_q ? pal_rdata : 24'd0) : s1_rgb_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rgb_q    <= s1_rgb_d;
      s1_pal_q    <= s1_pal_d;
      s1_hit_q    <= s1_hit_d;
      s1_status_q <= s1_status_d;
      s1_last_q   <= s1_last_d;
    end
    if (s1_valid_q && out_ready) begin
      out_beat_q.first_component  <= s1_color[7:0];
      out_beat_q.second_component <= s1_color[15:8];
      out_beat_q.third_component  <= s1_color[23:16];
      out_beat_q.status           <= s1_status_q;
      out_beat_q.last_pixel       <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule
